// ===== rtl/core/asrf_pkg.sv =====
// Shared types and constants for the audio sample ring FIFO.
// No dependencies; audio_sample_ring_fifo refers to this package.
`default_nettype none

package asrf_pkg;

    localparam int DEPTH_DEF       = 1024;
    localparam int MAX_REQUEST_DEF = 64;
    localparam int SAMPLE_W        = 16;
    localparam int REQ_W           = 7;
    localparam int CFG_DEPTH_W     = 11;
    localparam int CFG_DATA_W      = 16;

    typedef enum logic {
        CMD_PUT = 1'b0,
        CMD_GET = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_READ_OK     = 2'd0,
        ST_UNDERRUN    = 2'd1,
        ST_PUT_STORED  = 2'd2,
        ST_PUT_DROPPED = 2'd3
    } t_status;

    typedef enum logic {
        REG_DEPTH_IN_USE = 1'b0,
        REG_SILENCE      = 1'b1
    } t_reg_index;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_GET  = 1'b1
    } t_state;

    typedef struct packed {
        t_cmd                       command;
        logic signed [SAMPLE_W-1:0] in_sample;
        logic [REQ_W-1:0]           request_count;
        logic                       block_end;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_sample;
        t_status                    status;
        logic                       last;
    } t_out_item;

    typedef struct packed {
        t_reg_index             index;
        logic [CFG_DATA_W-1:0]  data;
    } t_cfg_item;

endpackage

`default_nettype wire

// ===== rtl/core/asrf_stream_if.sv =====
// Valid/ready channel carrying one payload of a type from asrf_pkg.
// Used for the put/get input, the result output and the register writes.
`default_nettype none

interface asrf_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/audio_sample_ring_fifo.sv =====
// Ring FIFO of signed audio samples with put / get-run commands and underrun fill.
// Depends on asrf_pkg and asrf_stream_if.
//
//  channel | dir | payload                                        | handshake
//  i_in    | in  | command, in_sample, request_count, block_end   | valid & ready
//  o_out   | out | out_sample, status, last                       | valid & ready
//  i_cfg   | in  | index (0 depth_in_use, 1 silence_value), data  | valid & ready
//
// A put issues a single element; a get of N samples issues N elements, one per cycle while
// the read stage can advance, paced by the single read port of the sample memory. Each result
// passes through the memory read stage and then the output register after its element issues.
// A get holds off new input transactions until its last element has issued.
// Synchronous active-low reset clears pointers and counts; the memory needs no clearing.
// Output stalls back up through the read stage into the element issue.
`default_nettype none

module audio_sample_ring_fifo #(
    parameter int DEPTH       = asrf_pkg::DEPTH_DEF,
    parameter int MAX_REQUEST = asrf_pkg::MAX_REQUEST_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    asrf_stream_if.sink   i_in,
    asrf_stream_if.source o_out,
    asrf_stream_if.sink   i_cfg
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > asrf_pkg::CFG_DEPTH_W) ? CNT_W : asrf_pkg::CFG_DEPTH_W;

    logic signed [asrf_pkg::SAMPLE_W-1:0] r_mem [DEPTH];
    logic signed [asrf_pkg::SAMPLE_W-1:0] r_mem_q;

    asrf_pkg::t_state r_state, n_state;
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_occ, r_depth_eff;
    logic signed [asrf_pkg::SAMPLE_W-1:0] r_silence;
    logic [asrf_pkg::REQ_W-1:0] r_remain;

    // read stage: one element waiting for memory data
    logic                                 r_s1_valid;
    logic                                 r_s1_from_mem;
    logic signed [asrf_pkg::SAMPLE_W-1:0] r_s1_sample;
    asrf_pkg::t_status                    r_s1_status;
    logic                                 r_s1_last;

    logic                r_out_valid;
    asrf_pkg::t_out_item r_out;

    logic                       s1_move, can_issue, in_ready, in_acc;
    logic                       acc_put, acc_get, get_elem, elem_last;
    logic                       put_store, rd_elem, cfg_acc;
    logic [asrf_pkg::REQ_W-1:0] req_clamped;
    logic [CMP_W-1:0]           cfg_depth;
    logic [CMP_W-1:0]           depth_clamped;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] depth);
        logic [CNT_W-1:0] nxt;
        nxt = CNT_W'(p) + CNT_W'(1);
        advance = (nxt >= depth) ? '0 : nxt[PTR_W-1:0];
    endfunction

    assign s1_move   = r_s1_valid && (!r_out_valid || o_out.ready);
    assign can_issue = !r_s1_valid || s1_move;
    assign in_acc    = i_in.valid && in_ready;
    assign cfg_acc   = i_cfg.valid && i_cfg.ready;

    assign req_clamped = (i_in.payload.request_count > asrf_pkg::REQ_W'(MAX_REQUEST))
                       ? asrf_pkg::REQ_W'(MAX_REQUEST) : i_in.payload.request_count;

    assign cfg_depth     = CMP_W'(i_cfg.payload.data[asrf_pkg::CFG_DEPTH_W-1:0]);
    assign depth_clamped = (cfg_depth < CMP_W'(2))     ? CMP_W'(2)
                         : (cfg_depth > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cfg_depth;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            asrf_pkg::S_IDLE: begin
                if (acc_get && !elem_last) n_state = asrf_pkg::S_GET;
            end
            asrf_pkg::S_GET: begin
                if (get_elem && elem_last) n_state = asrf_pkg::S_IDLE;
            end
            default: n_state = asrf_pkg::S_IDLE;
        endcase
    end

    // issue control
    always_comb begin
        in_ready  = 1'b0;
        get_elem  = 1'b0;
        elem_last = 1'b0;
        unique case (r_state)
            asrf_pkg::S_IDLE: begin
                in_ready  = can_issue;
                get_elem  = acc_get;
                elem_last = (req_clamped == asrf_pkg::REQ_W'(1));
            end
            asrf_pkg::S_GET: begin
                get_elem  = can_issue;
                elem_last = (r_remain == asrf_pkg::REQ_W'(1));
            end
            default: ;
        endcase
    end

    assign acc_put   = in_acc && (i_in.payload.command == asrf_pkg::CMD_PUT);
    assign acc_get   = in_acc && (i_in.payload.command == asrf_pkg::CMD_GET)
                       && (req_clamped != '0);
    assign put_store = acc_put && (r_occ < r_depth_eff);
    assign rd_elem   = get_elem && (r_occ != '0);

    // A put and a read never issue in the same cycle, and a read issued after a put
    // sees the written word, so no forwarding path is needed.
    always_ff @(posedge i_clk) begin
        if (put_store) r_mem[r_wp] <= i_in.payload.in_sample;
        if (rd_elem)   r_mem_q     <= r_mem[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= asrf_pkg::S_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_occ       <= '0;
            r_depth_eff <= CNT_W'(DEPTH);
            r_silence   <= '0;
            r_remain    <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (cfg_acc && i_cfg.payload.index == asrf_pkg::REG_DEPTH_IN_USE) begin
                r_depth_eff <= depth_clamped[CNT_W-1:0];
                r_wp        <= '0;
                r_rp        <= '0;
                r_occ       <= '0;
            end else if (put_store) begin
                r_wp  <= advance(r_wp, r_depth_eff);
                r_occ <= r_occ + CNT_W'(1);
            end else if (rd_elem) begin
                r_rp  <= advance(r_rp, r_depth_eff);
                r_occ <= r_occ - CNT_W'(1);
            end
            if (cfg_acc && i_cfg.payload.index == asrf_pkg::REG_SILENCE) begin
                r_silence <= i_cfg.payload.data[asrf_pkg::SAMPLE_W-1:0];
            end

            if (acc_get) begin
                r_remain <= req_clamped - asrf_pkg::REQ_W'(1);
            end else if (get_elem) begin
                r_remain <= r_remain - asrf_pkg::REQ_W'(1);
            end

            if (acc_put || get_elem) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload of the read stage and output register
    always_ff @(posedge i_clk) begin
        if (acc_put) begin
            r_s1_from_mem <= 1'b0;
            r_s1_sample   <= '0;
            r_s1_status   <= put_store ? asrf_pkg::ST_PUT_STORED : asrf_pkg::ST_PUT_DROPPED;
            r_s1_last     <= 1'b1;
        end else if (get_elem) begin
            r_s1_from_mem <= rd_elem;
            r_s1_sample   <= r_silence;
            r_s1_status   <= rd_elem ? asrf_pkg::ST_READ_OK : asrf_pkg::ST_UNDERRUN;
            r_s1_last     <= elem_last;
        end
        if (s1_move) begin
            r_out.out_sample <= r_s1_from_mem ? r_mem_q : r_s1_sample;
            r_out.status     <= r_s1_status;
            r_out.last       <= r_s1_last;
        end
    end

    assign i_in.ready    = in_ready;
    assign i_cfg.ready   = 1'b1;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= r_depth_eff)
        else $error("occupancy above depth in use");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp == r_rp) |-> (r_occ == '0 || r_occ == r_depth_eff))
        else $error("pointers equal with partial occupancy");

    a_get_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == asrf_pkg::S_GET) |-> !(i_in.valid && i_in.ready))
        else $error("input transaction taken during get run");

    a_put_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (put_store && !cfg_acc) |=> (r_occ == $past(r_occ) + CNT_W'(1)))
        else $error("stored put did not raise occupancy");
`endif

endmodule

`default_nettype wire
